FILE: hdl/mfe_pkg.sv
package mfe_pkg;

    // sizing of the block
    localparam int MAX_BANDS   = 32;
    localparam int MAX_BINS    = 1024;
    localparam int MAG_BITS    = 16;
    localparam int WEIGHT_FRAC = 15;

    // field widths
    localparam int OPCODE_W    = 1;
    localparam int EDGE_IDX_W  = 6;
    localparam int HZ_W        = 23;
    localparam int BAND_IDX_W  = 5;
    localparam int ENERGY_W    = 26;
    localparam int BAND_CNT_W  = 6;

    // derived widths
    localparam int EDGE_DEPTH  = MAX_BANDS + 2;
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
    localparam int BAND_W      = $clog2(MAX_BANDS);
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int FREQ_W      = BIN_W + HZ_W;
    localparam int WGT_W       = WEIGHT_FRAC + 1;
    localparam int PROD_W      = MAG_BITS + WGT_W;
    localparam int SUM_W       = 42;
    localparam int SH_W        = SUM_W - WEIGHT_FRAC;
    localparam int DIV_CNT_W   = $clog2(WEIGHT_FRAC);

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_EDGE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_BIN  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING = 1'b1;

    localparam logic [BAND_CNT_W-1:0] BAND_CNT_RST = BAND_CNT_W'(24);
    localparam logic [HZ_W-1:0]       SPACING_RST  = HZ_W'(12024);

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [EDGE_IDX_W-1:0] edge_index;
        logic [HZ_W-1:0]       edge_hz;
        logic [MAG_BITS-1:0]   magnitude;
        logic                  last_bin;
    } t_in;

    typedef struct packed {
        logic [BAND_IDX_W-1:0] band_index;
        logic [ENERGY_W-1:0]   band_energy;
        logic                  last_band;
    } t_out;

    typedef struct packed {
        logic            start;
        logic [HZ_W-1:0] num;
        logic [HZ_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              add;
        logic              clear;
        logic [BAND_W-1:0] idx;
    } t_acc_ctrl;

endpackage

FILE: hdl/mel_filterbank_energy.sv
// Mel triangular filterbank energy accumulator.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): an edge-write
// transaction stores one band edge frequency in the edge table. A bin
// transaction carries the magnitude of the next FFT bin; the block walks
// the active bands one at a time through a shared radix-2 restoring
// divider, a 16x16 multiplier and a saturating adder. States S_LD0 and
// S_LD1 prime the edge reads; then a band whose weight is zero passes
// through load, evaluate and advance, and a band on a slope also through
// the divider and accumulate. o_in_ready is low for the whole walk.
// Output channel (o_out_valid / i_out_ready / o_out_data): after a bin
// marked last_bin, one result transaction per active band follows in band
// order; last_band flags the final one. The result register holds while
// the receiver stalls, and the block waits. Once the final band is taken
// the sums and the bin counter are cleared. Reset (synchronous, active
// low) clears the sums and the bin counter and loads the configuration
// registers with their defaults; the edge table must be written before use.
// Configuration writes (i_cfg_we) are taken at once; the user must make
// them only while idle, as the block itself does not enforce it.
module mel_filterbank_energy (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mfe_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mfe_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [mfe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mfe_pkg::HZ_W-1:0]          i_cfg_data
);
    import mfe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD0,
        S_LD1,
        S_LDU,
        S_EVAL,
        S_DIV,
        S_ACC,
        S_NEXT,
        S_EMIT,
        S_WAIT
    } t_state;

    localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(MAX_BINS - 1);

    // sequencer and datapath registers
    t_state                r_state, n_state;
    logic [BAND_W-1:0]     r_band, n_band;
    logic [BAND_W-1:0]     r_n_last, n_n_last;
    logic [BIN_W-1:0]      r_bin, n_bin;
    logic [FREQ_W-1:0]     r_freq, n_freq;
    logic [MAG_BITS-1:0]   r_mag, n_mag;
    logic                  r_last_bin, n_last_bin;
    logic [HZ_W-1:0]       r_lo, n_lo;
    logic [HZ_W-1:0]       r_ce, n_ce;
    logic [HZ_W-1:0]       r_up, n_up;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out_data, n_out_data;
    logic [BAND_CNT_W-1:0] r_band_cnt, n_band_cnt;
    logic [HZ_W-1:0]       r_spacing, n_spacing;

    // edge table: one write and one registered read port
    logic [HZ_W-1:0]       r_edge_mem [EDGE_DEPTH];
    logic [HZ_W-1:0]       r_edge_q;
    logic [EDGE_AW-1:0]    rd_addr;
    logic                  edge_we;

    logic                  in_acc;
    logic [BAND_CNT_W-1:0] act_cnt;
    logic [FREQ_W-1:0]     f_lo, f_ce, f_up;
    logic                  on_left, on_right;

    t_div_req              div_req;
    logic [WGT_W-1:0]      div_quo;
    logic                  div_done;
    t_acc_ctrl             acc_ctrl;
    logic [ENERGY_W-1:0]   acc_energy;

    assign in_acc  = i_in_valid && o_in_ready;
    assign edge_we = in_acc && i_in_data.opcode == OP_EDGE
                     && i_in_data.edge_index < EDGE_IDX_W'(EDGE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[i_in_data.edge_index[EDGE_AW-1:0]] <= i_in_data.edge_hz;
        end
        r_edge_q <= r_edge_mem[rd_addr];
    end

    // read address: edges 0 and 1 prime the walk, then each band fetches its upper edge
    always_comb begin
        unique case (r_state)
            S_LD0:   rd_addr = EDGE_AW'(1);
            S_LD1:   rd_addr = EDGE_AW'(2);
            S_NEXT:  rd_addr = EDGE_AW'(r_band) + EDGE_AW'(3);
            default: rd_addr = '0;
        endcase
    end

    // zero count acts as one, oversize count as the maximum
    always_comb begin
        if (r_band_cnt == '0) begin
            act_cnt = BAND_CNT_W'(1);
        end else if (r_band_cnt > BAND_CNT_W'(MAX_BANDS)) begin
            act_cnt = BAND_CNT_W'(MAX_BANDS);
        end else begin
            act_cnt = r_band_cnt;
        end
    end

    // slope selection for the current band
    always_comb begin
        f_lo     = FREQ_W'(r_lo);
        f_ce     = FREQ_W'(r_ce);
        f_up     = FREQ_W'(r_up);
        on_left  = r_freq >= f_lo && r_freq <= f_ce && r_ce != r_lo;
        on_right = r_freq > f_ce && r_freq <= f_up && r_up != r_ce;
        div_req.start = r_state == S_EVAL && (on_left || on_right);
        if (on_left) begin
            div_req.num = HZ_W'(r_freq - f_lo);
            div_req.den = r_ce - r_lo;
        end else begin
            div_req.num = HZ_W'(f_up - r_freq);
            div_req.den = r_up - r_ce;
        end
    end

    always_comb begin
        acc_ctrl.add   = r_state == S_ACC;
        acc_ctrl.clear = r_state == S_WAIT && i_out_ready && r_out_data.last_band;
        acc_ctrl.idx   = r_band;
    end

    mfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    mfe_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (acc_ctrl),
        .i_addend (r_prod),
        .o_energy (acc_energy)
    );

    always_comb begin
        n_state     = r_state;
        n_band      = r_band;
        n_n_last    = r_n_last;
        n_bin       = r_bin;
        n_freq      = r_freq;
        n_mag       = r_mag;
        n_last_bin  = r_last_bin;
        n_lo        = r_lo;
        n_ce        = r_ce;
        n_up        = r_up;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_band_cnt  = r_band_cnt;
        n_spacing   = r_spacing;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.opcode == OP_BIN) begin
                    n_freq     = FREQ_W'(r_bin) * FREQ_W'(r_spacing);
                    n_mag      = i_in_data.magnitude;
                    n_last_bin = i_in_data.last_bin;
                    n_n_last   = BAND_W'(act_cnt - 1'b1);
                    n_band     = '0;
                    n_state    = S_LD0;
                end
            end
            S_LD0: begin
                n_lo    = r_edge_q;
                n_state = S_LD1;
            end
            S_LD1: begin
                n_ce    = r_edge_q;
                n_state = S_LDU;
            end
            S_LDU: begin
                n_up    = r_edge_q;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // zero weight leaves the sum as it is
                n_state = (on_left || on_right) ? S_DIV : S_NEXT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_prod  = PROD_W'(r_mag) * PROD_W'(div_quo);
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_band == r_n_last) begin
                    if (r_bin != BIN_MAX) begin
                        n_bin = r_bin + 1'b1;
                    end
                    n_band  = '0;
                    n_state = r_last_bin ? S_EMIT : S_IDLE;
                end else begin
                    // slide the edge window up by one band
                    n_band  = r_band + 1'b1;
                    n_lo    = r_ce;
                    n_ce    = r_up;
                    n_state = S_LDU;
                end
            end
            S_EMIT: begin
                n_out_valid            = 1'b1;
                n_out_data.band_index  = BAND_IDX_W'(r_band);
                n_out_data.band_energy = acc_energy;
                n_out_data.last_band   = r_band == r_n_last;
                n_state                = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_data.last_band) begin
                        n_bin   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_band  = r_band + 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BAND_COUNT:  n_band_cnt = i_cfg_data[BAND_CNT_W-1:0];
                REG_BIN_SPACING: n_spacing  = i_cfg_data;
                default:         n_spacing  = r_spacing;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin       <= '0;
            r_out_valid <= 1'b0;
            r_band_cnt  <= BAND_CNT_RST;
            r_spacing   <= SPACING_RST;
        end else begin
            r_state     <= n_state;
            r_bin       <= n_bin;
            r_out_valid <= n_out_valid;
            r_band_cnt  <= n_band_cnt;
            r_spacing   <= n_spacing;
        end
        r_band     <= n_band;
        r_n_last   <= n_n_last;
        r_freq     <= n_freq;
        r_mag      <= n_mag;
        r_last_bin <= n_last_bin;
        r_lo       <= n_lo;
        r_ce       <= n_ce;
        r_up       <= n_up;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hdl/mfe_div.sv
module mfe_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfe_pkg::t_div_req              i_req,
    output logic [mfe_pkg::WGT_W-1:0]      o_quo,
    output logic                           o_done
);
    import mfe_pkg::*;

    // restoring division of num * 2^WEIGHT_FRAC by den, num <= den
    logic [HZ_W-1:0]      r_rem;
    logic [HZ_W-1:0]      r_den;
    logic [WGT_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic                 first_ge;
    logic [HZ_W:0]        rem_sh;
    logic [HZ_W:0]        rem_sub;
    logic                 step_ge;

    always_comb begin
        first_ge = i_req.num >= i_req.den;
        rem_sh   = {r_rem, 1'b0};
        rem_sub  = rem_sh - {1'b0, r_den};
        step_ge  = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(WEIGHT_FRAC - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= first_ge ? (i_req.num - i_req.den) : i_req.num;
            r_den <= i_req.den;
            r_quo <= WGT_W'(first_ge);
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= step_ge ? rem_sub[HZ_W-1:0] : rem_sh[HZ_W-1:0];
            r_quo <= {r_quo[WGT_W-2:0], step_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

FILE: hdl/mfe_acc.sv
module mfe_acc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mfe_pkg::t_acc_ctrl              i_ctrl,
    input  logic [mfe_pkg::PROD_W-1:0]      i_addend,
    output logic [mfe_pkg::ENERGY_W-1:0]    o_energy
);
    import mfe_pkg::*;

    // per-band sums; an entry without its valid bit reads as zero
    logic [SUM_W-1:0]     r_sum [MAX_BANDS];
    logic [MAX_BANDS-1:0] r_valid;

    logic [SUM_W-1:0]     cur;
    logic [SUM_W:0]       tot;
    logic [SUM_W-1:0]     sat_sum;
    logic [SH_W-1:0]      sum_sh;

    always_comb begin
        cur     = r_valid[i_ctrl.idx] ? r_sum[i_ctrl.idx] : '0;
        tot     = {1'b0, cur} + (SUM_W + 1)'(i_addend);
        sat_sum = tot[SUM_W] ? '1 : tot[SUM_W-1:0];
        sum_sh  = cur[SUM_W-1:WEIGHT_FRAC];
        if ((sum_sh >> ENERGY_W) != '0) begin
            o_energy = '1;
        end else begin
            o_energy = sum_sh[ENERGY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.add) begin
            r_sum[i_ctrl.idx] <= sat_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= '0;
        end else if (i_ctrl.add) begin
            r_valid[i_ctrl.idx] <= 1'b1;
        end
    end

endmodule

FILE: hdl/mfe_checker.sv
module mfe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input mfe_pkg::t_in                      i_in_data,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input mfe_pkg::t_out                     o_out_data,
    input logic                              i_cfg_we,
    input logic [mfe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [mfe_pkg::HZ_W-1:0]          i_cfg_data
);
    import mfe_pkg::*;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    // no new item while a result is on offer
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");

    // after the final band of a frame the block is ready again
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_band |=> o_in_ready && !o_out_valid)
        else $error("block not idle after final band");

endmodule

bind mel_filterbank_energy mfe_checker u_mfe_checker (.*);
